// ===== rtl/core/warer_pkg.sv =====
// shared constants and types of the windowed arrival rate estimator
package warer_pkg;

	localparam int WINDOW   = 32;
	localparam int PTR_W    = $clog2(WINDOW);
	localparam int FILL_W   = $clog2(WINDOW + 1);
	localparam int CNT_W    = $clog2(WINDOW);
	localparam int GAP_W    = 6;
	localparam int SUM_W    = $clog2((WINDOW - 1) * ((1 << GAP_W) - 1) + 1);
	localparam int TIME_W   = 48;
	localparam int SEC_W    = 39;
	localparam int RATE_W   = 17;
	localparam int FRAC_W   = 16;
	localparam int MS_PER_S = 1000;
	localparam int MS_DIV_W = 10;

	// seconds conversion: one 16-bit millisecond digit per cycle
	localparam int SEC_DIG_W   = 16;
	localparam int SEC_STEPS   = TIME_W / SEC_DIG_W;
	localparam int SEC_CNT_W   = $clog2(SEC_STEPS);
	localparam int SEC_V_W     = MS_DIV_W + SEC_DIG_W;
	// 1000 = 8 * 125, the shift takes the factor of 8 and the multiply the 125
	localparam int MS_PRE_SH   = 3;
	localparam int MS_RECIP_SH = 30;
	localparam int MS_RECIP_W  = 24;
	localparam int SEC_P_W     = SEC_V_W - MS_PRE_SH + MS_RECIP_W;
	// ceil(2^30 / 125)
	localparam logic [MS_RECIP_W-1:0] MS_RECIP = MS_RECIP_W'(8589935);

	localparam int RATE_N_W = CNT_W + FRAC_W;
	localparam int DIV_N_W  = RATE_N_W;
	localparam int DIV_D_W  = SUM_W;
	localparam int STEP_W   = $clog2(DIV_N_W + 1);

	localparam int PADDR_W  = 3;
	localparam int PDATA_W  = 32;

	localparam logic [GAP_W-1:0]     MAX_GAP_RST = GAP_W'(10);
	localparam logic [RATE_W-1:0]    ONE_Q16     = RATE_W'(1 << FRAC_W);
	localparam logic [PADDR_W-3:0]   REG_MAX_GAP = '0;

	typedef struct packed {
		logic             done;
		logic             few;
		logic [CNT_W-1:0] cnt;
		logic [SUM_W-1:0] sum;
	} walk_res_t;

endpackage

// ===== rtl/core/warer_if.sv =====
// item channels of the estimator: event timestamps in, rate estimates out
interface warer_evt_if import warer_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [TIME_W-1:0] event_time_ms;

	modport source (output valid, output event_time_ms, input ready);
	modport sink (input valid, input event_time_ms, output ready);
endinterface

interface warer_est_if import warer_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [RATE_W-1:0] rate_q16;
	logic              is_default;

	modport source (output valid, output rate_q16, output is_default, input ready);
	modport sink (input valid, input rate_q16, input is_default, output ready);
endinterface

// ===== rtl/core/warer_div.sv =====
// iterative restoring divider, one quotient bit per cycle
module warer_div import warer_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [DIV_N_W-1:0] dividend,
	input  logic [DIV_D_W-1:0] divisor,
	input  logic [STEP_W-1:0]  steps,
	output logic               done,
	output logic [DIV_N_W-1:0] quot
);

	logic               busy_q;
	logic               done_q;
	logic [STEP_W-1:0]  left_q;
	logic [DIV_N_W-1:0] num_q;
	logic [DIV_D_W-1:0] den_q;
	logic [DIV_D_W-1:0] rem_q;
	logic [DIV_N_W-1:0] quot_q;

	logic [DIV_D_W:0]   rem_sh;
	logic [DIV_D_W:0]   trial;
	logic               ge;

	assign rem_sh = {rem_q, num_q[DIV_N_W-1]};
	assign ge     = rem_sh >= {1'b0, den_q};
	assign trial  = rem_sh - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			left_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				left_q <= steps;
			end else if (busy_q) begin
				left_q <= left_q - STEP_W'(1);
				if (left_q == STEP_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q  <= dividend;
			den_q  <= divisor;
			rem_q  <= '0;
			quot_q <= '0;
		end else if (busy_q) begin
			num_q  <= {num_q[DIV_N_W-2:0], 1'b0};
			quot_q <= {quot_q[DIV_N_W-2:0], ge};
			rem_q  <= ge ? trial[DIV_D_W-1:0] : rem_sh[DIV_D_W-1:0];
		end
	end

	assign done = done_q;
	assign quot = quot_q;

endmodule

// ===== rtl/core/warer_walk.sv =====
// timestamp ring in a synchronous memory and the newest-first gap walk
module warer_walk import warer_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             store,
	input  logic [SEC_W-1:0] secs,
	input  logic [GAP_W-1:0] max_gap,
	output walk_res_t        res
);

	logic [SEC_W-1:0]  ring_mem [WINDOW];

	logic [PTR_W-1:0]  wp_q;
	logic [FILL_W-1:0] fill_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [FILL_W-1:0] remain_q;
	logic              busy_q;
	logic              done_q;
	logic              few_q;
	logic              rd_v_s1;
	logic [SEC_W-1:0]  rd_data_s1;
	logic [SEC_W-1:0]  prev_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [SUM_W-1:0]  sum_q;

	logic [FILL_W-1:0] new_fill;
	logic              rd_en;
	logic [SEC_W:0]    diff;
	logic              take;

	assign new_fill = (fill_q == FILL_W'(WINDOW)) ? fill_q : fill_q + FILL_W'(1);
	assign rd_en    = busy_q && (remain_q != '0);

	// older entry must be strictly before the newer one and within the limit
	assign diff = {1'b0, prev_q} - {1'b0, rd_data_s1};
	assign take = rd_v_s1 && !diff[SEC_W] && (diff[SEC_W-1:0] != '0)
		&& (diff[SEC_W-1:GAP_W] == '0) && (diff[GAP_W-1:0] <= max_gap);

	always_ff @(posedge clk) begin
		if (store) begin
			ring_mem[wp_q] <= secs;
		end
		if (rd_en) begin
			rd_data_s1 <= ring_mem[rd_ptr_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q     <= '0;
			fill_q   <= '0;
			rd_ptr_q <= '0;
			remain_q <= '0;
			busy_q   <= 1'b0;
			done_q   <= 1'b0;
			few_q    <= 1'b0;
			rd_v_s1  <= 1'b0;
			cnt_q    <= '0;
			sum_q    <= '0;
		end else begin
			done_q  <= 1'b0;
			rd_v_s1 <= rd_en;
			if (store) begin
				wp_q     <= (wp_q == PTR_W'(WINDOW - 1)) ? '0 : wp_q + PTR_W'(1);
				fill_q   <= new_fill;
				// newest stored entry is held in prev, so reads start one slot further back
				rd_ptr_q <= (wp_q == '0) ? PTR_W'(WINDOW - 1) : wp_q - PTR_W'(1);
				remain_q <= new_fill - FILL_W'(1);
				cnt_q    <= '0;
				sum_q    <= '0;
				if (new_fill < FILL_W'(2)) begin
					few_q  <= 1'b1;
					done_q <= 1'b1;
				end else begin
					few_q  <= 1'b0;
					busy_q <= 1'b1;
				end
			end else if (busy_q) begin
				if (rd_en) begin
					rd_ptr_q <= (rd_ptr_q == '0) ? PTR_W'(WINDOW - 1) : rd_ptr_q - PTR_W'(1);
					remain_q <= remain_q - FILL_W'(1);
				end
				if (take) begin
					cnt_q <= cnt_q + CNT_W'(1);
					sum_q <= sum_q + SUM_W'(diff[GAP_W-1:0]);
				end
				if (!rd_en && !rd_v_s1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (store) begin
			prev_q <= secs;
		end else if (rd_v_s1) begin
			prev_q <= rd_data_s1;
		end
	end

	assign res.done = done_q;
	assign res.few  = few_q;
	assign res.cnt  = cnt_q;
	assign res.sum  = sum_q;

endmodule

// ===== rtl/core/windowed_arrival_rate_estimator_unit.sv =====
// Windowed arrival rate estimator: one rate estimate per event timestamp, items taken one at
// a time. A zero timestamp goes straight to its default estimate. Any other item is converted
// to seconds one 16-bit millisecond digit per cycle by reciprocal multiply, then the walk
// reads the timestamp memory one entry per cycle; the very first stored entry skips the
// reads. When fewer than two gaps count the estimate is the default, and otherwise it comes
// from the 21-step bit-serial rate division. The next item is taken the cycle after an
// estimate moves into the output register, so an estimate waiting to be collected only holds
// off the item after next. max_gap_seconds sits at byte address 0 of the register port.
module windowed_arrival_rate_estimator_unit import warer_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready,
	warer_evt_if.sink          evt,
	warer_est_if.source        est
);

	typedef enum logic [4:0] {
		S_IDLE = 5'b00001,
		S_SEC  = 5'b00010,
		S_WALK = 5'b00100,
		S_RATE = 5'b01000,
		S_DONE = 5'b10000
	} state_t;

	state_t                       state_q;
	logic [GAP_W-1:0]             max_gap_q;
	logic [RATE_W-1:0]            res_rate_q;
	logic                         res_def_q;
	logic                         est_valid_q;
	logic [RATE_W-1:0]            est_rate_q;
	logic                         est_def_q;
	logic [TIME_W-1:0]            sec_num_q;
	logic [MS_DIV_W-1:0]          sec_rem_q;
	logic [SEC_W-1:0]             sec_quot_q;
	logic [SEC_CNT_W-1:0]         sec_left_q;

	logic                         accept;
	logic                         ts_zero;
	logic                         sec_last;
	logic [SEC_V_W-1:0]           sec_v;
	logic [SEC_V_W-MS_PRE_SH-1:0] sec_y;
	logic [SEC_P_W-1:0]           sec_prod;
	logic [SEC_DIG_W-1:0]         sec_qd;
	logic [SEC_V_W-1:0]           sec_back;
	logic [SEC_W-1:0]             sec_next;
	logic                         div_start;
	logic [DIV_N_W-1:0]           div_dividend;
	logic [DIV_D_W-1:0]           div_divisor;
	logic [STEP_W-1:0]            div_steps;
	logic                         div_done;
	logic [DIV_N_W-1:0]           div_quot;
	logic                         store;
	walk_res_t                    walk_res;
	logic                         walk_use;
	logic                         out_free;
	logic                         cfg_wr;
	logic                         cfg_hit;

	// register port
	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite;
	assign cfg_hit = paddr[PADDR_W-1:2] == REG_MAX_GAP;
	assign prdata  = cfg_hit ? PDATA_W'(max_gap_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_gap_q <= MAX_GAP_RST;
		end else if (cfg_wr && cfg_hit) begin
			max_gap_q <= pwdata[GAP_W-1:0];
		end
	end

	assign evt.ready = state_q == S_IDLE;
	assign accept    = evt.valid && evt.ready;
	assign ts_zero   = evt.event_time_ms == '0;
	assign sec_last  = sec_left_q == '0;
	assign store     = (state_q == S_SEC) && sec_last;
	assign walk_use  = !walk_res.few && (walk_res.cnt >= CNT_W'(2));
	assign out_free  = !est_valid_q || est.ready;

	// long division by 1000, top digit first, remainder carried into the next digit
	assign sec_v    = {sec_rem_q, sec_num_q[TIME_W-1 -: SEC_DIG_W]};
	assign sec_y    = sec_v[SEC_V_W-1:MS_PRE_SH];
	assign sec_prod = SEC_P_W'(sec_y) * SEC_P_W'(MS_RECIP);
	assign sec_qd   = sec_prod[MS_RECIP_SH +: SEC_DIG_W];
	assign sec_back = sec_v - SEC_V_W'(sec_qd) * SEC_V_W'(MS_PER_S);
	assign sec_next = {sec_quot_q[SEC_W-SEC_DIG_W-1:0], sec_qd};

	always_ff @(posedge clk) begin
		if (accept) begin
			sec_num_q  <= evt.event_time_ms;
			sec_rem_q  <= '0;
			sec_quot_q <= '0;
		end else if (state_q == S_SEC) begin
			sec_num_q  <= {sec_num_q[TIME_W-SEC_DIG_W-1:0], SEC_DIG_W'(0)};
			sec_rem_q  <= sec_back[MS_DIV_W-1:0];
			sec_quot_q <= sec_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sec_left_q <= '0;
		end else if (accept) begin
			sec_left_q <= SEC_CNT_W'(SEC_STEPS - 1);
		end else if ((state_q == S_SEC) && !sec_last) begin
			sec_left_q <= sec_left_q - SEC_CNT_W'(1);
		end
	end

	// rate = (count << 16) / sum
	assign div_start    = (state_q == S_WALK) && walk_res.done && walk_use;
	assign div_dividend = {walk_res.cnt, {FRAC_W{1'b0}}};
	assign div_divisor  = DIV_D_W'(walk_res.sum);
	assign div_steps    = STEP_W'(RATE_N_W);

	warer_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.steps    (div_steps),
		.done     (div_done),
		.quot     (div_quot)
	);

	warer_walk u_walk (
		.clk     (clk),
		.arst_n  (arst_n),
		.store   (store),
		.secs    (sec_next),
		.max_gap (max_gap_q),
		.res     (walk_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= ts_zero ? S_DONE : S_SEC;
					end
				end
				S_SEC: begin
					if (sec_last) begin
						state_q <= S_WALK;
					end
				end
				S_WALK: begin
					if (walk_res.done) begin
						state_q <= walk_use ? S_RATE : S_DONE;
					end
				end
				S_RATE: begin
					if (div_done) begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if ((accept && ts_zero) || ((state_q == S_WALK) && walk_res.done && !walk_use)) begin
			res_rate_q <= ONE_Q16;
			res_def_q  <= 1'b1;
		end else if ((state_q == S_RATE) && div_done) begin
			res_rate_q <= div_quot[RATE_W-1:0];
			res_def_q  <= 1'b0;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			est_valid_q <= 1'b0;
		end else if ((state_q == S_DONE) && out_free) begin
			est_valid_q <= 1'b1;
		end else if (est.ready) begin
			est_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == S_DONE) && out_free) begin
			est_rate_q <= res_rate_q;
			est_def_q  <= res_def_q;
		end
	end

	assign est.valid      = est_valid_q;
	assign est.rate_q16   = est_rate_q;
	assign est.is_default = est_def_q;

endmodule

// ===== tb/tb_windowed_arrival_rate_estimator_unit.sv =====
// self-checking testbench of the windowed arrival rate estimator unit
`timescale 1ns / 100ps

module tb_windowed_arrival_rate_estimator_unit;
	import warer_pkg::*;

	localparam int STALL_LIMIT  = 3000;
	localparam int DRAIN_CYCLES = 120;
	localparam int LONG_HOLD    = 400;
	localparam int HOLD_AFTER   = 40;
	localparam int N_DIRECTED   = 23;

	localparam logic [PADDR_W-1:0] ADDR_MAX_GAP  = {REG_MAX_GAP, 2'b00};
	localparam logic [PADDR_W-1:0] ADDR_UNMAPPED = {1'b1, 2'b00};

	localparam logic TYPED   = 1'b1;
	localparam logic PREDICT = 1'b0;

	typedef struct packed {
		logic [RATE_W-1:0] rate;
		logic              is_default;
	} rate_est_t;

	typedef struct packed {
		logic [TIME_W-1:0] ms;
		logic              typed;
		logic [RATE_W-1:0] rate;
		logic              is_default;
	} evt_row_t;

	// directed items, reset gap limit of 10 s; typed rows carry their own answer
	localparam evt_row_t [0:N_DIRECTED-1] DIRECTED_ROWS = {
		{48'd0,               TYPED,   ONE_Q16, 1'b1},  // zero timestamp
		{48'hFFFF_FFFF_FFFF,  TYPED,   ONE_Q16, 1'b1},  // first entry only
		{48'd1000,            TYPED,   ONE_Q16, 1'b1},  // backwards gap
		{48'd2000,            TYPED,   ONE_Q16, 1'b1},  // one valid gap
		{48'd3999,            TYPED,   ONE_Q16, 1'b0},  // two 1 s gaps, top rate
		{48'd0,               TYPED,   ONE_Q16, 1'b1},  // state left alone
		{48'd4000,            PREDICT, 17'd0,   1'b0},
		{48'd14000,           PREDICT, 17'd0,   1'b0},  // gap equal to limit
		{48'd25000,           PREDICT, 17'd0,   1'b0},  // gap over limit
		{48'd25999,           PREDICT, 17'd0,   1'b0},  // zero gap
		{48'd1,               PREDICT, 17'd0,   1'b0},
		{48'h8000_0000_0000,  PREDICT, 17'd0,   1'b0},
		{48'h8000_0000_1B58,  PREDICT, 17'd0,   1'b0},
		{48'h8000_0000_2710,  PREDICT, 17'd0,   1'b0},
		{48'h5555_5555_5555,  PREDICT, 17'd0,   1'b0},
		{48'hAAAA_AAAA_AAAA,  PREDICT, 17'd0,   1'b0},
		{48'd999,             PREDICT, 17'd0,   1'b0},
		{48'd2000,            PREDICT, 17'd0,   1'b0},
		{48'd4500,            PREDICT, 17'd0,   1'b0},
		{48'd6999,            PREDICT, 17'd0,   1'b0},
		{48'd9000,            PREDICT, 17'd0,   1'b0},
		{48'd0,               PREDICT, 17'd0,   1'b0},
		{48'd1,               PREDICT, 17'd0,   1'b0}
	};

	logic               clk;
	logic               arst_n;
	logic               psel;
	logic               penable;
	logic               pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [PDATA_W-1:0] pwdata;
	logic [PDATA_W-1:0] prdata;
	logic               pready;

	warer_evt_if evt_ch ();
	warer_est_if est_ch ();

	windowed_arrival_rate_estimator_unit uut (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.evt     (evt_ch),
		.est     (est_ch)
	);

	// own copy of the estimator state
	logic [SEC_W-1:0]  arrival_ring [WINDOW];
	int                next_slot;
	int                stored_cnt;
	logic [GAP_W-1:0]  gap_limit;

	rate_est_t         expected_rates [$];
	int                err_cnt;
	int                results_seen;
	int                stall_cycles;
	int                send_idle_pct;
	int                recv_idle_pct;
	logic [TIME_W-1:0] cur_ms;

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	task automatic note_error(input string msg);
		err_cnt++;
		if (err_cnt <= 10) begin
			$display("%s", msg);
		end
	endtask

	// stores the stamp in seconds (zero stamps aside) and works out the rate over the stored window
	function automatic rate_est_t predict_rate(input logic [TIME_W-1:0] ms);
		rate_est_t        r;
		logic [SEC_W-1:0] newer;
		logic [SEC_W-1:0] older;
		int unsigned      n_valid;
		int unsigned      gap_sum;
		int               i;
		r.rate = ONE_Q16;
		r.is_default = 1'b1;
		n_valid = 0;
		gap_sum = 0;
		if (ms == '0) begin
			return r;
		end
		arrival_ring[next_slot] = SEC_W'(ms / MS_PER_S);
		next_slot = (next_slot + 1) % WINDOW;
		if (stored_cnt < WINDOW) begin
			stored_cnt++;
		end
		if (stored_cnt < 2) begin
			return r;
		end
		// newest gap first; with a full ring the oldest slot is the next one to write
		for (i = 1; i < stored_cnt; i++) begin
			newer = arrival_ring[(next_slot + WINDOW - i) % WINDOW];
			older = arrival_ring[(next_slot + WINDOW - i - 1) % WINDOW];
			if (newer > older && (newer - older) <= gap_limit) begin
				gap_sum += 32'(newer - older);
				n_valid++;
			end
		end
		if (n_valid < 2 || gap_sum == 0) begin
			return r;
		end
		r.rate = RATE_W'((n_valid << FRAC_W) / gap_sum);
		r.is_default = 1'b0;
		return r;
	endfunction

	task automatic offer_event(input evt_row_t row);
		rate_est_t pred;
		@(negedge clk);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			evt_ch.valid <= 1'b0;
			@(negedge clk);
		end
		evt_ch.valid <= 1'b1;
		evt_ch.event_time_ms <= row.ms;
		@(posedge clk);
		while (!evt_ch.ready) begin
			@(posedge clk);
		end
		pred = predict_rate(row.ms);
		if (row.typed) begin
			expected_rates.push_back({row.rate, row.is_default});
		end else begin
			expected_rates.push_back(pred);
		end
		// the item is taken, so it must not be offered again
		@(negedge clk);
		evt_ch.valid <= 1'b0;
	endtask

	// mostly rising timestamps with gaps around the limit, some zeros, noise and steps back
	task automatic run_event_traffic(input int n_items);
		evt_row_t row;
		int       pick;
		int       k;
		for (k = 0; k < n_items; k++) begin
			row = '0;
			pick = $urandom_range(0, 99);
			if (pick < 4) begin
				row.ms = '0;
			end else if (pick < 10) begin
				row.ms = TIME_W'({$urandom(), $urandom()});
			end else if (pick < 14) begin
				row.ms = cur_ms - TIME_W'($urandom_range(0, 5000));
			end else begin
				if ($urandom_range(0, 39) == 0) begin
					cur_ms = TIME_W'({$urandom(), $urandom()}) >> $urandom_range(0, 40);
				end
				cur_ms = cur_ms + TIME_W'($urandom_range(0, (int'(gap_limit) + 2) * 1000));
				row.ms = cur_ms;
			end
			offer_event(row);
		end
	endtask

	task automatic wait_for_results();
		while (expected_rates.size() != 0) begin
			@(posedge clk);
		end
	endtask

	task automatic apb_write(input logic [PADDR_W-1:0] addr, input logic [PDATA_W-1:0] data);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= data;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) begin
			@(posedge clk);
		end
		if (addr[PADDR_W-1:2] == REG_MAX_GAP) begin
			gap_limit = data[GAP_W-1:0];
		end
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic apb_read_check(input logic [PADDR_W-1:0] addr);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= addr;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) begin
			@(posedge clk);
		end
		if (prdata !== PDATA_W'(gap_limit)) begin
			note_error($sformatf("max_gap_seconds read back: expected %0d, got %0d",
				gap_limit, prdata));
		end
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	// receiver: random back-pressure, plus one long hold-off so the input stalls
	initial begin
		int hold_left;
		bit hold_done;
		hold_left = 0;
		hold_done = 1'b0;
		est_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (!hold_done && results_seen >= HOLD_AFTER) begin
				hold_left = LONG_HOLD;
				hold_done = 1'b1;
			end
			if (hold_left != 0) begin
				hold_left--;
				est_ch.ready <= 1'b0;
			end else begin
				est_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
			end
		end
	end

	always @(posedge clk) begin : rate_check
		rate_est_t want;
		if (arst_n && est_ch.valid && est_ch.ready) begin
			results_seen++;
			if (expected_rates.size() == 0) begin
				note_error($sformatf("unexpected rate estimate: rate %0d default %0b",
					est_ch.rate_q16, est_ch.is_default));
			end else begin
				want = expected_rates.pop_front();
				if (est_ch.rate_q16 !== want.rate || est_ch.is_default !== want.is_default) begin
					note_error($sformatf(
						"rate estimate mismatch: expected rate %0d default %0b, got rate %0d default %0b",
						want.rate, want.is_default, est_ch.rate_q16, est_ch.is_default));
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((evt_ch.valid && evt_ch.ready) || (est_ch.valid && est_ch.ready)) begin
			stall_cycles = 0;
		end else begin
			stall_cycles++;
		end
		if (stall_cycles >= STALL_LIMIT) begin
			$display("watchdog: no item moved for %0d cycles", STALL_LIMIT);
			$display("tb_windowed_arrival_rate_estimator_unit: done, errors");
			$finish;
		end
	end

	initial begin
		int i;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		evt_ch.valid = 1'b0;
		evt_ch.event_time_ms = '0;
		next_slot = 0;
		stored_cnt = 0;
		gap_limit = MAX_GAP_RST;
		err_cnt = 0;
		results_seen = 0;
		stall_cycles = 0;
		send_idle_pct = 19;
		recv_idle_pct = 56;
		cur_ms = 48'd100000;

		repeat (9) @(negedge clk);
		arst_n <= 1'b1;

		for (i = 0; i < N_DIRECTED; i++) begin
			offer_event(DIRECTED_ROWS[i]);
		end
		wait_for_results();
		apb_read_check(ADDR_MAX_GAP);

		// a limit of 1 s: only 1 s gaps count
		apb_write(ADDR_MAX_GAP, PDATA_W'(1));
		apb_read_check(ADDR_MAX_GAP);
		run_event_traffic(180);
		wait_for_results();

		send_idle_pct = 56;
		recv_idle_pct = 19;
		apb_write(ADDR_MAX_GAP, PDATA_W'(63));
		apb_read_check(ADDR_MAX_GAP);
		run_event_traffic(180);
		wait_for_results();

		// a zero limit leaves every answer at the default
		send_idle_pct = 0;
		recv_idle_pct = 0;
		apb_write(ADDR_MAX_GAP, PDATA_W'(0));
		apb_read_check(ADDR_MAX_GAP);
		run_event_traffic(30);
		wait_for_results();

		// write past the register list must not land anywhere
		apb_write(ADDR_UNMAPPED, PDATA_W'(5));
		apb_write(ADDR_MAX_GAP, {$urandom()} & ~PDATA_W'(63) | PDATA_W'($urandom_range(2, 62)));
		apb_read_check(ADDR_MAX_GAP);
		run_event_traffic(140);

		@(negedge clk);
		evt_ch.valid <= 1'b0;
		wait_for_results();
		repeat (DRAIN_CYCLES) @(posedge clk);
		while (expected_rates.size() != 0) begin
			void'(expected_rates.pop_front());
			note_error("rate estimate never arrived");
		end

		if (err_cnt == 0) begin
			$display("tb_windowed_arrival_rate_estimator_unit: done, clean");
		end else begin
			$display("tb_windowed_arrival_rate_estimator_unit: done, errors");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/core/warer_pkg.sv
rtl/core/warer_if.sv
rtl/core/warer_div.sv
rtl/core/warer_walk.sv
rtl/core/windowed_arrival_rate_estimator_unit.sv
tb/tb_windowed_arrival_rate_estimator_unit.sv
